/* src/cop_pkg.sv */
// Shared types and constants of the circle outline point generator.
package cop_pkg;

  localparam int unsigned CoordW  = 11;
  localparam int unsigned RadiusW = 10;
  localparam int unsigned SquareW = 20;

  localparam logic [RadiusW-1:0] RadiusReset = 10'd600;

  typedef logic [2:0] pt_idx_t;

  // Point order within a run: bit 2 swaps the offsets, bit 1 negates the
  // first coordinate offset, bit 0 negates the second.
  localparam pt_idx_t IdxFirst    = 3'd0;
  localparam pt_idx_t AxisJumpAt  = 3'd1;
  localparam pt_idx_t AxisJumpTo  = 3'd4;
  localparam pt_idx_t AxisSkipAt  = 3'd4;
  localparam pt_idx_t AxisSkipTo  = 3'd6;
  localparam pt_idx_t AxisLast    = 3'd6;
  localparam pt_idx_t OctantLast  = 3'd7;

  typedef struct packed {
    logic              axis;
    logic [CoordW-1:0] a;
    logic [CoordW-1:0] b;
    logic              done;
  } run_t;

  typedef struct packed {
    logic              tracing;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } status_t;

endpackage

/* src/cop_in_if.sv */
// Request channel carrying the restart flag of one tick.
interface cop_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

/* src/cop_out_if.sv */
// Result channel carrying one outline point.
interface cop_out_if;
  logic                         valid;
  logic                         ready;
  logic [cop_pkg::CoordW-1:0]   pixel_x;
  logic [cop_pkg::CoordW-1:0]   pixel_y;
  logic                         last_of_run;
  logic                         trace_done;

  modport source (output valid, output pixel_x, output pixel_y, output last_of_run,
                  output trace_done, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input last_of_run,
                input trace_done, output ready);
endinterface

/* src/circle_outline_point_generator.sv */
// Top level of the circle outline point generator with the radius register.
// The first point of a request passes through the run register and then the output register.
// Throughput: one point per cycle while the receiver is ready, so 8 points per step request, 4 per restart, and
// none for a step that emits nothing; the run register walking the points sets this.
// Reset clears the trace state and the pipeline and sets the radius to 600.
module circle_outline_point_generator #(
  parameter int unsigned IMAGE_WIDTH  = 2048,
  parameter int unsigned IMAGE_HEIGHT = 2048
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cop_pkg::RadiusW-1:0] cfg_wdata_i,
  cop_in_if.sink                      req_i,
  cop_out_if.source                   res_o
);

  localparam logic [cop_pkg::CoordW-1:0] CenterX = cop_pkg::CoordW'(IMAGE_WIDTH / 2);
  localparam logic [cop_pkg::CoordW-1:0] CenterY = cop_pkg::CoordW'(IMAGE_HEIGHT / 2);

  logic [cop_pkg::RadiusW-1:0] radius_q;
  logic                        in_fire, emit, emit_ready;
  cop_pkg::run_t               run;
  cop_pkg::status_t            status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= cop_pkg::RadiusReset;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  assign req_i.ready = emit_ready;
  assign in_fire     = req_i.valid && req_i.ready;

  cop_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (in_fire),
    .restart_i (req_i.restart),
    .radius_i  (radius_q),
    .emit_o    (emit),
    .run_o     (run),
    .status_o  (status)
  );

  cop_emit #(
    .CENTER_X (CenterX),
    .CENTER_Y (CenterY)
  ) u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_fire && emit),
    .run_i   (run),
    .ready_o (emit_ready),
    .res_o   (res_o)
  );

  // The trace continues exactly while the step offset is below the outline offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.tracing == (status.x < status.y))
    else $error("tracing flag disagrees with step offsets");

  // A restart always leaves the step offset at one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && req_i.restart |=> status.x == 11'd1)
    else $error("restart did not reset the step offset");

  // A restart with a radius of two or more starts a trace whose height is the radius.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && req_i.restart && (radius_q > 10'd1)
    |=> status.tracing && (status.y == {1'b0, $past(radius_q)}))
    else $error("restart did not start a trace at the radius");

  // A step taken while not tracing leaves the trace state untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !req_i.restart && !status.tracing |=> $stable(status))
    else $error("idle step changed the trace state");

endmodule

/* src/cop_step.sv */
// Trace state and its registered update with incremental rounded square root.
module cop_step (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic                        restart_i,
  input  logic [cop_pkg::RadiusW-1:0] radius_i,
  output logic                        emit_o,
  output cop_pkg::run_t               run_o,
  output cop_pkg::status_t            status_o
);

  logic [cop_pkg::CoordW-1:0]  x_q, x_d, y_q, y_d;
  logic [cop_pkg::SquareW-1:0] rem_q, rem_d, sq_q, sq_d;
  logic                        tracing_q, tracing_d;

  logic [cop_pkg::SquareW-1:0] r2, r_ext, dec, rem_step, y2, t2, t3;
  logic                        r_big;

  // sq_q holds y*y - y, the lower bound of the rounding interval of y.
  assign r_ext    = {10'd0, radius_i};
  assign r2       = r_ext * r_ext;
  assign r_big    = radius_i > 10'd1;
  assign dec      = {8'd0, x_q, 1'b0} + 20'd1;
  assign rem_step = (rem_q > dec) ? (rem_q - dec) : '0;
  assign y2       = {8'd0, y_q, 1'b0};
  assign t2       = sq_q - y2 + 20'd2;
  assign t3       = t2 - y2 + 20'd4;

  always_comb begin
    priority if (restart_i) begin
      x_d   = 11'd1;
      rem_d = (r2 == '0) ? '0 : (r2 - 20'd1);
      y_d   = r_big ? {1'b0, radius_i} : '0;
      sq_d  = r_big ? (r2 - r_ext) : '0;
    end else if (tracing_q) begin
      x_d   = x_q + 11'd1;
      rem_d = rem_step;
      priority if (rem_step > sq_q) begin
        y_d  = y_q;
        sq_d = sq_q;
      end else if (rem_step > t2) begin
        y_d  = y_q - 11'd1;
        sq_d = t2;
      end else begin
        y_d  = y_q - 11'd2;
        sq_d = t3;
      end
    end else begin
      x_d   = x_q;
      y_d   = y_q;
      rem_d = rem_q;
      sq_d  = sq_q;
    end
    tracing_d = x_d < y_d;
  end

  assign emit_o     = restart_i || tracing_q;
  assign run_o.axis = restart_i;
  assign run_o.a    = restart_i ? '0 : x_q;
  assign run_o.b    = restart_i ? {1'b0, radius_i} : y_q;
  assign run_o.done = !tracing_d;

  assign status_o.tracing = tracing_q;
  assign status_o.x       = x_q;
  assign status_o.y       = y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= '0;
      y_q       <= '0;
      rem_q     <= '0;
      sq_q      <= '0;
      tracing_q <= 1'b0;
    end else if (fire_i) begin
      x_q       <= x_d;
      y_q       <= y_d;
      rem_q     <= rem_d;
      sq_q      <= sq_d;
      tracing_q <= tracing_d;
    end
  end

endmodule

/* src/cop_emit.sv */
// Run register that walks the symmetric points of one run into an output register.
module cop_emit #(
  parameter logic [cop_pkg::CoordW-1:0] CENTER_X = 11'd1024,
  parameter logic [cop_pkg::CoordW-1:0] CENTER_Y = 11'd1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  cop_pkg::run_t run_i,
  output logic          ready_o,
  cop_out_if.source     res_o
);

  cop_pkg::run_t    run_q;
  cop_pkg::pt_idx_t idx_q, idx_d, idx_nxt;
  logic             busy_q, busy_d;
  logic             adv, pt_last;

  logic                       out_valid_q;
  logic [cop_pkg::CoordW-1:0] px_q, py_q, px_d, py_d, u, v;
  logic                       last_q, done_q;

  assign adv     = busy_q && (!out_valid_q || res_o.ready);
  assign pt_last = run_q.axis ? (idx_q == cop_pkg::AxisLast) : (idx_q == cop_pkg::OctantLast);
  assign ready_o = !busy_q || (adv && pt_last);

  always_comb begin
    priority if (run_q.axis && idx_q == cop_pkg::AxisJumpAt) begin
      idx_nxt = cop_pkg::AxisJumpTo;
    end else if (run_q.axis && idx_q == cop_pkg::AxisSkipAt) begin
      idx_nxt = cop_pkg::AxisSkipTo;
    end else begin
      idx_nxt = idx_q + 3'd1;
    end
  end

  always_comb begin
    priority if (load_i) begin
      busy_d = 1'b1;
      idx_d  = cop_pkg::IdxFirst;
    end else if (adv) begin
      busy_d = !pt_last;
      idx_d  = idx_nxt;
    end else begin
      busy_d = busy_q;
      idx_d  = idx_q;
    end
  end

  assign u    = idx_q[2] ? run_q.b : run_q.a;
  assign v    = idx_q[2] ? run_q.a : run_q.b;
  assign px_d = idx_q[1] ? (CENTER_X - u) : (CENTER_X + u);
  assign py_d = idx_q[0] ? (CENTER_Y - v) : (CENTER_Y + v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= cop_pkg::IdxFirst;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      run_q <= run_i;
    end
    if (adv) begin
      px_q   <= px_d;
      py_q   <= py_d;
      last_q <= pt_last;
      done_q <= run_q.done;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.pixel_x     = px_q;
  assign res_o.pixel_y     = py_q;
  assign res_o.last_of_run = last_q;
  assign res_o.trace_done  = done_q;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for the circle outline point generator: random requests checked against a predictor.
module tb_top;

  typedef logic [cop_pkg::CoordW-1:0] coord_t;
  typedef logic [cop_pkg::RadiusW-1:0] radius_t;
  typedef logic [cop_pkg::SquareW-1:0] square_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    logic   last;
    logic   done;
  } outline_point_t;

  localparam coord_t CenterX = 11'd1024;
  localparam coord_t CenterY = 11'd1024;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TargetRequests = 300;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  radius_t cfg_wdata;

  cop_in_if req_if ();
  cop_out_if res_if ();

  circle_outline_point_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  logic pending_requests[$];
  outline_point_t expected_points[$];

  radius_t radius_q;
  coord_t x_q;
  coord_t y_q;
  square_t rsq_q;
  logic tracing_q;

  int unsigned busy_requests;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned hold_left;
  logic no_idle;
  logic hold_req;
  logic hold_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic coord_t nearest_root(square_t v);
    int unsigned s;
    int unsigned t;
    int b;
    s = 0;
    for (b = 10; b >= 0; b--) begin
      t = s | (1 << b);
      if (t * t <= v) s = t;
    end
    if (v > s * s + s) s = s + 1;
    return coord_t'(s);
  endfunction

  task automatic trace_tick(input logic restart);
    coord_t ax [8];
    coord_t ay [8];
    coord_t r;
    square_t sq;
    int unsigned dec;
    int n;
    int k;
    outline_point_t pt;
    n = 0;
    busy_requests++;
    if (restart) begin
      r = coord_t'(radius_q);
      ax[0] = CenterX;     ay[0] = CenterY + r;
      ax[1] = CenterX;     ay[1] = CenterY - r;
      ax[2] = CenterX + r; ay[2] = CenterY;
      ax[3] = CenterX - r; ay[3] = CenterY;
      n = 4;
      sq = square_t'(radius_q) * square_t'(radius_q);
      rsq_q = (sq != 0) ? sq - 1'b1 : '0;
      x_q = 11'd1;
    end else if (tracing_q) begin
      ax[0] = CenterX + x_q; ay[0] = CenterY + y_q;
      ax[1] = CenterX + x_q; ay[1] = CenterY - y_q;
      ax[2] = CenterX - x_q; ay[2] = CenterY + y_q;
      ax[3] = CenterX - x_q; ay[3] = CenterY - y_q;
      ax[4] = CenterX + y_q; ay[4] = CenterY + x_q;
      ax[5] = CenterX + y_q; ay[5] = CenterY - x_q;
      ax[6] = CenterX - y_q; ay[6] = CenterY + x_q;
      ax[7] = CenterX - y_q; ay[7] = CenterY - x_q;
      n = 8;
      dec = 2 * x_q + 1;
      rsq_q = (rsq_q > dec) ? square_t'(rsq_q - dec) : '0;
      x_q = x_q + 1'b1;
    end
    if (n != 0) begin
      y_q = nearest_root(rsq_q);
      tracing_q = x_q < y_q;
      for (k = 0; k < n; k++) begin
        pt.px = ax[k];
        pt.py = ay[k];
        pt.last = (k == n - 1);
        pt.done = !tracing_q;
        expected_points.push_back(pt);
      end
    end
  endtask

  task automatic check_point();
    outline_point_t got;
    outline_point_t want;
    got.px = res_if.pixel_x;
    got.py = res_if.pixel_y;
    got.last = res_if.last_of_run;
    got.done = res_if.trace_done;
    if (expected_points.size() == 0) begin
      mismatch_cnt++;
      $display("%0t: expected no point, got x=%0d y=%0d last=%0b done=%0b", $time,
               got.px, got.py, got.last, got.done);
    end else begin
      want = expected_points.pop_front();
      if (got.px !== want.px || got.py !== want.py || got.last !== want.last ||
          got.done !== want.done) begin
        mismatch_cnt++;
        $display("%0t: expected x=%0d y=%0d last=%0b done=%0b, got x=%0d y=%0d last=%0b done=%0b",
                 $time, want.px, want.py, want.last, want.done,
                 got.px, got.py, got.last, got.done);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.restart <= 1'b0;
      send_gap <= 0;
      radius_q = cop_pkg::RadiusReset;
      x_q = '0;
      y_q = '0;
      rsq_q = '0;
      tracing_q = 1'b0;
    end else begin
      if (cfg_we) radius_q = cfg_wdata;
      if (req_if.valid && req_if.ready) trace_tick(req_if.restart);
      if (!req_if.valid || req_if.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() != 0 && !no_idle &&
                     $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 14);
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          req_if.valid <= 1'b1;
          req_if.restart <= pending_requests.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) check_point();
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= HoldCycles - 1;
        res_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        res_if.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 14);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || req_if.valid || expected_points.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_radius(input radius_t value);
    wait_drained();
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic queue_requests(input logic restart, input int unsigned count);
    repeat (count) pending_requests.push_back(restart);
  endtask

  initial begin
    int unsigned kind;
    int unsigned r;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Steps before any restart are ignored, then a trace at the reset radius.
    queue_requests(1'b0, 2);
    queue_requests(1'b1, 1);
    queue_requests(1'b0, 1);
    set_radius(10'd0);
    queue_requests(1'b1, 1);
    queue_requests(1'b0, 1);
    set_radius(10'd1);
    queue_requests(1'b1, 1);
    queue_requests(1'b0, 1);
    set_radius(10'd1023);
    wait_drained();
    // The receiver holds off for a long stretch while requests keep coming.
    hold_req = 1'b1;
    queue_requests(1'b1, 1);
    queue_requests(1'b0, 8);
    // A new radius written mid-trace leaves the running trace alone.
    set_radius(10'd5);
    queue_requests(1'b0, 2);
    queue_requests(1'b1, 1);
    queue_requests(1'b0, 4);
    set_radius(10'd2);
    queue_requests(1'b1, 1);
    queue_requests(1'b0, 2);
    wait_drained();

    while (busy_requests < TargetRequests) begin
      no_idle = (busy_requests >= TargetRequests - 60) || ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
        r = $urandom_range(0, 40);
        set_radius(radius_t'(r));
        queue_requests(1'b1, 1);
        queue_requests(1'b0, $urandom_range(0, r + 3));
      end else if (kind < 16) begin
        set_radius(radius_t'($urandom_range(0, 1023)));
        queue_requests(1'b1, 1);
        queue_requests(1'b0, $urandom_range(1, 24));
      end else if (kind < 18) begin
        set_radius(radius_t'($urandom_range(0, 1023)));
        queue_requests(1'b0, $urandom_range(1, 16));
      end else begin
        repeat (12) pending_requests.push_back(1'($urandom_range(0, 1)));
      end
      wait_drained();
    end

    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* circle_outline_point_generator.f */
src/cop_pkg.sv
src/cop_in_if.sv
src/cop_out_if.sv
src/cop_step.sv
src/cop_emit.sv
src/circle_outline_point_generator.sv
verif/tb_top.sv
